FILE: rtl/pstd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_pkg: shared definitions for the prime sum block
// widths of the limit, the sum and the working registers, and their types
// ----------------------------------------------------------------------------
package pstd_pkg;

  localparam int LIMIT_BITS = 12;
  localparam int SUM_BITS   = 21;
  localparam int CAND_BITS  = LIMIT_BITS + 1;
  localparam int SQ_BITS    = LIMIT_BITS + 2;
  localparam int IDX_BITS   = (LIMIT_BITS > 1) ? $clog2(LIMIT_BITS) : 1;

  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

endpackage

FILE: rtl/pstd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_in_if / pstd_out_if: valid/ready channels of the prime sum block
// one carries the limit item, the other the sum item
// ----------------------------------------------------------------------------
interface pstd_in_if;
  import pstd_pkg::*;
  logic   valid;
  logic   ready;
  limit_t limit;
  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface pstd_out_if;
  import pstd_pkg::*;
  logic valid;
  logic ready;
  sum_t prime_sum;
  modport source (output valid, output prime_sum, input ready);
  modport sink   (input valid, input prime_sum, output ready);
endinterface

FILE: rtl/prime_sum_trial_division_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sum_trial_division_top: sum of primes up to a limit
// tests every candidate by trial division with a bit-serial remainder
// ----------------------------------------------------------------------------
//   channel  direction  payload              handshake
//   in_i     in         limit     [11:0]     valid/ready
//   out_o    out        prime_sum [20:0]     valid/ready
//
// one item at a time: ready only while idle, busy until the sum is taken
// each candidate is tried against divisors from two while their square is at
// most the candidate, each by a bit-serial remainder loop over LIMIT_BITS
// bits on the shared adder, which then also adds a prime to the sum
// reset clears the sequencer, the sum is held until out_o.ready
// ----------------------------------------------------------------------------
module prime_sum_trial_division_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pstd_in_if.sink    in_i,
  pstd_out_if.source out_o
);
  import pstd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAND = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [LIMIT_BITS-1:0] lim_q, lim_d;
  logic [CAND_BITS-1:0]  n_q, n_d;
  logic [LIMIT_BITS-1:0] d_q, d_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  logic [LIMIT_BITS-1:0] rem_q, rem_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [SUM_BITS-1:0]   acc_q, acc_d;

  // shared adder/subtractor
  logic [SUM_BITS-1:0] alu_a, alu_b;
  logic                alu_sub;
  logic [SUM_BITS:0]   alu_res;
  logic [LIMIT_BITS:0] trial;

  assign trial   = {rem_q, n_q[idx_q]};
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{SUM_BITS{1'b0}}, alu_sub};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_TEST: begin
        alu_a = acc_q;
        alu_b = SUM_BITS'(n_q);
      end
      S_DIV: begin
        alu_a   = SUM_BITS'(trial);
        alu_b   = SUM_BITS'(d_q);
        alu_sub = 1'b1;
      end
      S_CHK: begin
        alu_a = SUM_BITS'(sq_q);
        alu_b = SUM_BITS'({d_q, 1'b1});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    lim_d   = lim_q;
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          lim_d   = in_i.limit;
          n_d     = CAND_BITS'(2);
          acc_d   = '0;
          state_d = S_CAND;
        end
      end
      S_CAND: begin
        if (n_q > CAND_BITS'(lim_q)) begin
          state_d = S_DONE;
        end else begin
          d_d     = LIMIT_BITS'(2);
          sq_d    = SQ_BITS'(4);
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (sq_q > SQ_BITS'(n_q)) begin
          acc_d   = alu_res[SUM_BITS-1:0];
          state_d = S_NEXT;
        end else begin
          rem_d   = '0;
          idx_d   = IDX_BITS'(LIMIT_BITS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = alu_res[SUM_BITS] ? alu_res[LIMIT_BITS-1:0] : trial[LIMIT_BITS-1:0];
        idx_d = idx_q - IDX_BITS'(1);
        if (idx_q == '0) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (rem_q == '0) begin
          state_d = S_NEXT;
        end else begin
          sq_d    = alu_res[SQ_BITS-1:0];
          d_d     = d_q + LIMIT_BITS'(1);
          state_d = S_TEST;
        end
      end
      S_NEXT: begin
        n_d     = n_q + CAND_BITS'(1);
        state_d = S_CAND;
      end
      S_DONE: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    n_q   <= n_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    idx_q <= idx_d;
    acc_q <= acc_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_DONE);
  assign out_o.prime_sum = acc_q;

  // checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_CAND && acc_q == '0 && n_q == CAND_BITS'(2))
    else $error("item start not set up");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < d_q)
    else $error("remainder not below divisor");

  a_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TEST |-> (2*SQ_BITS)'(sq_q) == (2*SQ_BITS)'(d_q) * (2*SQ_BITS)'(d_q))
    else $error("square tracking lost");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready |=> in_i.ready && !out_o.valid)
    else $error("not idle after sum taken");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for prime_sum_trial_division_top
// walks a table of limits, then random ones under phases of sender idling and
// sink stalls, checking each sum against a typed-in or trial-division sum
// ----------------------------------------------------------------------------
module tb;
  import pstd_pkg::*;

  typedef struct packed {
    limit_t lim;
    logic   known;
    sum_t   sum;
  } lim_row_t;

  typedef struct packed {
    limit_t lim;
    sum_t   sum;
  } sum_exp_t;

  localparam int NUM_ROWS  = 23;
  localparam int NUM_RAND  = 76;
  localparam int NUM_PHASE = 4;

  // limits below two hold no primes; small sums typed in, the rest predicted
  localparam lim_row_t LIM_ROWS [NUM_ROWS] = '{
    '{limit_t'(0),    1'b1, sum_t'(0)},
    '{limit_t'(1),    1'b1, sum_t'(0)},
    '{limit_t'(2),    1'b1, sum_t'(2)},
    '{limit_t'(3),    1'b1, sum_t'(5)},
    '{limit_t'(4),    1'b1, sum_t'(5)},
    '{limit_t'(5),    1'b1, sum_t'(10)},
    '{limit_t'(6),    1'b0, sum_t'(0)},
    '{limit_t'(7),    1'b1, sum_t'(17)},
    '{limit_t'(8),    1'b0, sum_t'(0)},
    '{limit_t'(9),    1'b0, sum_t'(0)},
    '{limit_t'(10),   1'b1, sum_t'(17)},
    '{limit_t'(11),   1'b1, sum_t'(28)},
    '{limit_t'(12),   1'b0, sum_t'(0)},
    '{limit_t'(13),   1'b1, sum_t'(41)},
    '{limit_t'(25),   1'b0, sum_t'(0)},
    '{limit_t'(49),   1'b0, sum_t'(0)},
    '{limit_t'(120),  1'b0, sum_t'(0)},
    '{limit_t'(121),  1'b0, sum_t'(0)},
    '{limit_t'(127),  1'b0, sum_t'(0)},
    '{limit_t'(128),  1'b0, sum_t'(0)},
    '{limit_t'(4095), 1'b0, sum_t'(0)},
    '{limit_t'(1),    1'b1, sum_t'(0)},
    '{limit_t'(2),    1'b1, sum_t'(2)}
  };

  logic clk_i;
  logic rst_ni;

  pstd_in_if  lim_if ();
  pstd_out_if sum_if ();

  prime_sum_trial_division_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (lim_if),
    .out_o  (sum_if)
  );

  sum_exp_t    sum_q[$];
  int unsigned err_cnt    = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic sum_t sum_primes_upto(limit_t lim);
    int unsigned acc = 0;
    int unsigned n;
    int unsigned d;
    bit          is_prime;
    for (n = 2; n <= lim; n++) begin
      is_prime = 1'b1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          is_prime = 1'b0;
          break;
        end
      end
      if (is_prime) acc += n;
    end
    return sum_t'(acc);
  endfunction

  // valid stays high between back-to-back items, lowered only for a gap
  task automatic send_limit(limit_t lim, sum_t sum);
    if ($urandom_range(99) < idle_pct) begin
      lim_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    lim_if.valid <= 1'b1;
    lim_if.limit <= lim;
    do @(posedge clk_i); while (!lim_if.ready);
    sum_q.push_back('{lim: lim, sum: sum});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_if.ready <= 1'b0;
    end else begin
      sum_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sum_exp_t want;
    if (rst_ni && sum_if.valid && sum_if.ready) begin
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got prime_sum %0d",
                 $time, sum_if.prime_sum);
        err_cnt++;
      end else begin
        want = sum_q.pop_front();
        if (sum_if.prime_sum !== want.sum) begin
          $display("%0t: limit %0d prime_sum expected %0d, got %0d",
                   $time, want.lim, want.sum, sum_if.prime_sum);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    limit_t lim;
    int unsigned pick;
    lim_if.valid <= 1'b0;
    lim_if.limit <= '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_limit(LIM_ROWS[i].lim, LIM_ROWS[i].known ? LIM_ROWS[i].sum :
                 sum_primes_upto(LIM_ROWS[i].lim));
    end

    // idling phases: none, sender, sink, both
    for (int ph = 0; ph < NUM_PHASE; ph++) begin
      idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 22 : 0;
      stall_pct = (ph == 2) ? 60 : (ph == 3) ? 22 : 0;
      for (int i = 0; i < NUM_RAND / NUM_PHASE; i++) begin
        pick = $urandom_range(99);
        // mostly small limits, the run time grows fast with the limit
        if (pick < 70)      lim = limit_t'($urandom_range(63));
        else if (pick < 90) lim = limit_t'($urandom_range(255, 64));
        else                lim = limit_t'($urandom_range(511, 256));
        send_limit(lim, sum_primes_upto(lim));
      end
    end
    lim_if.valid <= 1'b0;

    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
